[sv/iqd_pkg.sv]
// shared types, constants and coefficient rom for the iq iir decimator
package iqd_pkg;

    localparam int unsigned SAMPLE_W  = 24;
    localparam int unsigned HIST_W    = 40;
    localparam int unsigned COEF_W    = 32;
    localparam int unsigned ROM_STAGES = 5;
    localparam int unsigned NUM_SETS  = 3;
    localparam int unsigned NUM_CH    = 2;
    localparam int unsigned NUM_TAPS  = 5;

    localparam logic [1:0] MODE_BYPASS = 2'd0;

    localparam logic signed [HIST_W-1:0] H40_MAX = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic signed [HIST_W-1:0] H40_MIN = {1'b1, {(HIST_W-1){1'b0}}};

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd1073741824;

    // tap order: b0 (x), b1 (x1), b2 (x2), a1 (y1), a2 (y2)
    function automatic logic signed [COEF_W-1:0] coef_rom(
        input logic [1:0] set_sel,
        input logic [2:0] stage,
        input logic [2:0] tap
    );
        logic signed [COEF_W-1:0] c;
        c = '0;
        if ({29'd0, stage} >= ROM_STAGES) begin
            c = (tap == 3'd0) ? COEF_ONE : '0;
        end else begin
            case ({set_sel, stage, tap})
                {2'd0, 3'd0, 3'd0}: c = 32'sd7271593;
                {2'd0, 3'd0, 3'd1}: c = 32'sd13361434;
                {2'd0, 3'd0, 3'd2}: c = 32'sd7271593;
                {2'd0, 3'd0, 3'd3}: c = 32'sd1125971417;
                {2'd0, 3'd0, 3'd4}: c = -32'sd363955154;
                {2'd0, 3'd1, 3'd0}: c = 32'sd1073741824;
                {2'd0, 3'd1, 3'd1}: c = 32'sd1128580409;
                {2'd0, 3'd1, 3'd2}: c = 32'sd1073741824;
                {2'd0, 3'd1, 3'd3}: c = 32'sd791504690;
                {2'd0, 3'd1, 3'd4}: c = -32'sd588387946;
                {2'd0, 3'd2, 3'd0}: c = 32'sd1073741824;
                {2'd0, 3'd2, 3'd1}: c = 32'sd508362021;
                {2'd0, 3'd2, 3'd2}: c = 32'sd1073741824;
                {2'd0, 3'd2, 3'd3}: c = 32'sd459716086;
                {2'd0, 3'd2, 3'd4}: c = -32'sd814646286;
                {2'd0, 3'd3, 3'd0}: c = 32'sd1073741824;
                {2'd0, 3'd3, 3'd1}: c = 32'sd213933125;
                {2'd0, 3'd3, 3'd2}: c = 32'sd1073741824;
                {2'd0, 3'd3, 3'd3}: c = 32'sd265455231;
                {2'd0, 3'd3, 3'd4}: c = -32'sd957153501;
                {2'd0, 3'd4, 3'd0}: c = 32'sd1073741824;
                {2'd0, 3'd4, 3'd1}: c = 32'sd102985251;
                {2'd0, 3'd4, 3'd2}: c = 32'sd1073741824;
                {2'd0, 3'd4, 3'd3}: c = 32'sd185751307;
                {2'd0, 3'd4, 3'd4}: c = -32'sd1040812467;
                {2'd1, 3'd0, 3'd0}: c = 32'sd642608;
                {2'd1, 3'd0, 3'd1}: c = 32'sd787987;
                {2'd1, 3'd0, 3'd2}: c = 32'sd642608;
                {2'd1, 3'd0, 3'd3}: c = 32'sd1675533458;
                {2'd1, 3'd0, 3'd4}: c = -32'sd675320080;
                {2'd1, 3'd1, 3'd0}: c = 32'sd1073741824;
                {2'd1, 3'd1, 3'd1}: c = -32'sd592095349;
                {2'd1, 3'd1, 3'd2}: c = 32'sd1073741824;
                {2'd1, 3'd1, 3'd3}: c = 32'sd1637996424;
                {2'd1, 3'd1, 3'd4}: c = -32'sd783232568;
                {2'd1, 3'd2, 3'd0}: c = 32'sd1073741824;
                {2'd1, 3'd2, 3'd1}: c = -32'sd1192028613;
                {2'd1, 3'd2, 3'd2}: c = 32'sd1073741824;
                {2'd1, 3'd2, 3'd3}: c = 32'sd1597078162;
                {2'd1, 3'd2, 3'd4}: c = -32'sd907810928;
                {2'd1, 3'd3, 3'd0}: c = 32'sd1073741824;
                {2'd1, 3'd3, 3'd1}: c = -32'sd1385574105;
                {2'd1, 3'd3, 3'd2}: c = 32'sd1073741824;
                {2'd1, 3'd3, 3'd3}: c = 32'sd1574949291;
                {2'd1, 3'd3, 3'd4}: c = -32'sd995984110;
                {2'd1, 3'd4, 3'd0}: c = 32'sd1073741824;
                {2'd1, 3'd4, 3'd1}: c = -32'sd1448537069;
                {2'd1, 3'd4, 3'd2}: c = 32'sd1073741824;
                {2'd1, 3'd4, 3'd3}: c = 32'sd1577054996;
                {2'd1, 3'd4, 3'd4}: c = -32'sd1051471151;
                {2'd2, 3'd0, 3'd0}: c = 32'sd196041;
                {2'd2, 3'd0, 3'd1}: c = -32'sd5466;
                {2'd2, 3'd0, 3'd2}: c = 32'sd196041;
                {2'd2, 3'd0, 3'd3}: c = 32'sd1912264275;
                {2'd2, 3'd0, 3'd4}: c = -32'sd857771471;
                {2'd2, 3'd1, 3'd0}: c = 32'sd1073741824;
                {2'd2, 3'd1, 3'd1}: c = -32'sd1645244106;
                {2'd2, 3'd1, 3'd2}: c = 32'sd1073741824;
                {2'd2, 3'd1, 3'd3}: c = 32'sd1932686368;
                {2'd2, 3'd1, 3'd4}: c = -32'sd916269798;
                {2'd2, 3'd2, 3'd0}: c = 32'sd1073741824;
                {2'd2, 3'd2, 3'd1}: c = -32'sd1878803140;
                {2'd2, 3'd2, 3'd2}: c = 32'sd1073741824;
                {2'd2, 3'd2, 3'd3}: c = 32'sd1956986191;
                {2'd2, 3'd2, 3'd4}: c = -32'sd983843485;
                {2'd2, 3'd3, 3'd0}: c = 32'sd1073741824;
                {2'd2, 3'd3, 3'd1}: c = -32'sd1941798021;
                {2'd2, 3'd3, 3'd2}: c = 32'sd1073741824;
                {2'd2, 3'd3, 3'd3}: c = 32'sd1976191399;
                {2'd2, 3'd3, 3'd4}: c = -32'sd1031686660;
                {2'd2, 3'd4, 3'd0}: c = 32'sd1073741824;
                {2'd2, 3'd4, 3'd1}: c = -32'sd1961218870;
                {2'd2, 3'd4, 3'd2}: c = 32'sd1073741824;
                {2'd2, 3'd4, 3'd3}: c = 32'sd1992921033;
                {2'd2, 3'd4, 3'd4}: c = -32'sd1061748197;
                default:            c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

[sv/iqd_mac.sv]
// pipelined q30 product unit: floor(v * c / 2^30) accumulated over one stage
module iqd_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_first,
    input  logic                                i_last,
    input  logic signed [iqd_pkg::HIST_W-1:0]   i_v,
    input  logic signed [iqd_pkg::COEF_W-1:0]   i_c,
    output logic                                o_valid,
    output logic signed [iqd_pkg::HIST_W-1:0]   o_y
);
    localparam int unsigned PW = iqd_pkg::HIST_W + iqd_pkg::COEF_W;
    localparam int unsigned AW = PW - 30 + 3;

    // stage 1: split coefficient into high and low parts for two narrower multiplies
    logic signed [iqd_pkg::HIST_W-1:0] r_v;
    logic signed [16:0]                r_ch;
    logic        [14:0]                r_cl;
    logic                              r_v1, r_f1, r_l1;
    // stage 2: partial products
    logic signed [iqd_pkg::HIST_W+16:0] r_ph;
    logic signed [iqd_pkg::HIST_W+15:0] r_pl;
    logic                               r_v2, r_f2, r_l2;
    // stage 3: floored product and accumulate
    logic signed [AW-1:0]               r_acc;
    logic                               r_v3;
    logic signed [PW-1:0]               n_prod;
    logic signed [AW-1:0]               n_term, n_acc;

    always_ff @(posedge i_clk) begin
        r_v  <= i_v;
        r_ch <= 17'(i_c >>> 15);
        r_cl <= i_c[14:0];
        r_ph <= r_v * r_ch;
        r_pl <= r_v * $signed({1'b0, r_cl});
        r_f2 <= r_f1;
        r_l2 <= r_l1;
        r_f1 <= i_first;
        r_l1 <= i_last;
        if (r_v2) begin
            r_acc <= n_acc;
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_l2;
        end
    end

    always_comb begin
        n_prod = (PW'(r_ph) <<< 15) + PW'(r_pl);
        n_term = AW'(n_prod >>> 30);
        n_acc  = r_f2 ? n_term : r_acc + n_term;
    end

    assign o_valid = r_v3;
    assign o_y = (r_acc > AW'(iqd_pkg::H40_MAX)) ? iqd_pkg::H40_MAX :
                 (r_acc < AW'(iqd_pkg::H40_MIN)) ? iqd_pkg::H40_MIN :
                 iqd_pkg::HIST_W'(r_acc);
endmodule

[sv/iqd_hist_ram.sv]
// filter history memory, one 40-bit word per entry, registered read
module iqd_hist_ram #(
    parameter int unsigned DEPTH = 120,
    parameter int unsigned AW    = 7
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [iqd_pkg::HIST_W-1:0]  i_wdata,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [iqd_pkg::HIST_W-1:0]  o_rdata
);
    logic signed [iqd_pkg::HIST_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/iq_iir_decimator_top.sv]
// top level: stream wrapper, sequencer over history memory and shared mac
// bypass: output registered, one transfer per cycle while the output is free; filtered items
// take per stage and channel a history read, five mac taps, the mac pipeline and four writes
// one filtered item in flight; the next transfer waits until it is done, longer on output stall
// reset clears mode, phase and output valid, then a clearing pass writes every
// history entry (3*2*NUM_STAGES*4, 120 by default); a clear command reruns it
module iq_iir_decimator_top #(
    parameter int unsigned NUM_STAGES   = 5,
    parameter int unsigned PHASE_PERIOD = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // i_in[23:0], q_in[47:24]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // i_out[23:0], q_out[47:24]
);
    localparam int unsigned DEPTH = iqd_pkg::NUM_SETS * iqd_pkg::NUM_CH * NUM_STAGES * 4;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int unsigned PHW   = $clog2(PHASE_PERIOD);
    localparam int unsigned HW    = iqd_pkg::HIST_W;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_MAC, ST_WAIT, ST_WB, ST_OUT
    } t_state;

    t_state              r_state;
    logic [1:0]          r_mode;
    logic [PHW-1:0]      r_phase;
    logic [AW-1:0]       r_clr;
    logic [SW-1:0]       r_stage;
    logic                r_ch;
    logic [2:0]          r_tap;
    logic [2:0]          r_ws;
    logic signed [HW-1:0] r_x, r_q, r_h0, r_h2, r_y, r_yi;
    logic                r_emit;
    logic                r_ovalid;
    logic [47:0]         r_odata;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic signed [HW-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0]       base;
    logic                mac_valid, mac_first, mac_last, mac_ovalid;
    logic signed [HW-1:0] mac_v, mac_y;
    logic signed [iqd_pkg::COEF_W-1:0] mac_c;
    logic [1:0]          set_sel;
    logic                out_free;
    logic                out_load;
    logic signed [HW-1:0] in_i, in_q;

    function automatic logic [23:0] to_out24(input logic signed [HW-1:0] v);
        logic signed [HW:0] r;
        r = ($signed({v[HW-1], v}) + (HW+1)'(64)) >>> 7;
        if (r > (HW+1)'(8388607))       return 24'h7FFFFF;
        else if (r < -(HW+1)'(8388608)) return 24'h800000;
        else                            return r[23:0];
    endfunction

    assign set_sel  = r_mode - 2'd1;
    assign base     = AW'((((32'(set_sel) * 2 + 32'(r_ch)) * NUM_STAGES) + 32'(r_stage)) * 4);
    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_i = HW'($signed(s_axis_tdata[23:0])) <<< 7;
    assign in_q = HW'($signed(s_axis_tdata[47:24])) <<< 7;
    assign out_load = ((r_state == ST_IDLE) && s_axis_tvalid && s_axis_tready &&
                       !s_axis_tuser && (r_mode == iqd_pkg::MODE_BYPASS)) ||
                      ((r_state == ST_OUT) && r_emit && out_free);

    // history word order per stage: x1, x2, y1, y2; word t-1 is read the cycle before tap t
    assign ram_raddr = ((r_state == ST_MAC) && (r_tap inside {[3'd1:3'd3]})) ?
                       base + AW'(r_tap) : base;

    always_comb begin
        mac_valid = (r_state == ST_MAC);
        mac_first = (r_tap == 3'd1);
        mac_last  = (r_tap == 3'd0);
        mac_c     = iqd_pkg::coef_rom(set_sel, 3'(r_stage), r_tap);
        mac_v     = (r_tap == 3'd0) ? r_x : ram_rdata;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = base;
        ram_wdata = '0;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
        end else if (r_state == ST_WB) begin
            ram_we    = 1'b1;
            ram_waddr = base + AW'(r_ws);
            case (r_ws)
                3'd0:    ram_wdata = r_x;
                3'd1:    ram_wdata = r_h0;
                3'd2:    ram_wdata = r_y;
                default: ram_wdata = r_h2;
            endcase
        end
    end

    // the mac streams taps while reads feed it; x1 and y1 are kept for shifting
    iqd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mac_valid),
        .i_first (mac_first),
        .i_last  (mac_last),
        .i_v     (mac_v),
        .i_c     (mac_c),
        .o_valid (mac_ovalid),
        .o_y     (mac_y)
    );

    iqd_hist_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_mode   <= iqd_pkg::MODE_BYPASS;
            r_phase  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_stage  <= '0;
            r_ch     <= 1'b0;
            r_tap    <= '0;
            r_ws     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_clr   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr <= r_clr + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        if (s_axis_tuser) begin
                            r_phase <= '0;
                            r_state <= ST_CLEAR;
                        end else if (r_mode == iqd_pkg::MODE_BYPASS) begin
                            r_odata  <= s_axis_tdata;
                        end else begin
                            r_x     <= in_i;
                            r_q     <= in_q;
                            r_emit  <= (r_phase & PHW'((32'd1 << r_mode) - 1)) == '0;
                            r_phase <= (32'(r_phase) == PHASE_PERIOD - 1) ? '0
                                                                          : r_phase + PHW'(1);
                            r_stage <= '0;
                            r_ch    <= 1'b0;
                            r_tap   <= 3'd1;
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    // first read in flight; its word feeds tap 1 next cycle
                    r_state <= ST_MAC;
                end
                ST_MAC: begin
                    if (r_tap == 3'd1) r_h0 <= ram_rdata;
                    if (r_tap == 3'd3) r_h2 <= ram_rdata;
                    if (r_tap == 3'd0) begin
                        r_state <= ST_WAIT;
                    end else if (r_tap == 3'd4) begin
                        r_tap <= 3'd0;
                    end else begin
                        r_tap <= r_tap + 3'd1;
                    end
                end
                ST_WAIT: begin
                    if (mac_ovalid) begin
                        r_y     <= mac_y;
                        r_ws    <= '0;
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    r_ws <= r_ws + 3'd1;
                    if (r_ws == 3'd3) begin
                        r_tap <= 3'd1;
                        if (32'(r_stage) == NUM_STAGES - 1) begin
                            r_stage <= '0;
                            if (r_ch) begin
                                r_state <= ST_OUT;
                            end else begin
                                r_ch    <= 1'b1;
                                r_x     <= r_q;
                                r_yi    <= r_y;
                                r_state <= ST_READ;
                            end
                        end else begin
                            r_x     <= r_y;
                            r_stage <= r_stage + SW'(1);
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_emit) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_odata  <= {to_out24(r_y), to_out24(r_yi)};
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // no input transfer while a filtered item or clearing pass is in progress
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_odata)))
        else $error("pending result changed");
    a_wb_only_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |-> (r_mode != iqd_pkg::MODE_BYPASS))
        else $error("history write in bypass mode");
    a_mac_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_ovalid |-> (r_state == ST_WAIT))
        else $error("mac result outside wait");
endmodule

[tb/tb_top.sv]
// testbench for the iq iir decimator: stream driver, monitor and bit-exact predictor
`timescale 1ns / 1ps

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;
    localparam logic [1:0] MODE_DEC2 = 2'd1;
    localparam logic [1:0] MODE_DEC4 = 2'd2;
    localparam logic [1:0] MODE_DEC8 = 2'd3;
    localparam int LIMIT_CYCLES = 1500000;

    typedef struct packed {
        logic        cmd;
        logic [23:0] q;
        logic [23:0] i;
    } sample_t;

    iq_iir_decimator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predictor state
    logic signed [39:0] hist [3][2][5][4];
    logic [3:0]         phase;
    logic [1:0]         mode;

    sample_t     pending_q[$];
    logic [47:0] expected_q[$];
    int          errors;
    int          n_results;
    int          n_sent;
    longint      cycles;
    bit          quiet;

    function automatic logic signed [39:0] sat40(logic signed [79:0] v);
        if (v > 80'sd549755813887) return iqd_pkg::H40_MAX;
        if (v < -80'sd549755813888) return iqd_pkg::H40_MIN;
        return v[39:0];
    endfunction

    function automatic logic signed [39:0] biquad_cascade(int m, int ch,
                                                          logic signed [39:0] x_in);
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [79:0] acc;
        logic signed [79:0] prod;
        logic signed [39:0] taps [5];
        x = x_in;
        for (int s = 0; s < 5; s++) begin
            taps[0] = x;
            for (int t = 1; t < 5; t++) taps[t] = hist[m][ch][s][t-1];
            acc = '0;
            for (int t = 0; t < 5; t++) begin
                prod = 80'(taps[t]) * 80'(iqd_pkg::coef_rom(2'(m), 3'(s), 3'(t)));
                acc += (prod >>> 30);
            end
            y = sat40(acc);
            hist[m][ch][s][1] = hist[m][ch][s][0];
            hist[m][ch][s][0] = x;
            hist[m][ch][s][3] = hist[m][ch][s][2];
            hist[m][ch][s][2] = y;
            x = y;
        end
        return x;
    endfunction

    function automatic logic [23:0] round_out(logic signed [39:0] v);
        logic signed [40:0] r;
        r = (41'(v) + 41'sd64) >>> 7;
        if (r > 41'sd8388607) return 24'h7fffff;
        if (r < -41'sd8388608) return 24'h800000;
        return r[23:0];
    endfunction

    task automatic predict_sample(sample_t s);
        logic signed [39:0] yi;
        logic signed [39:0] yq;
        bit emit;
        if (s.cmd == CMD_CLEAR) begin
            foreach (hist[a, b, c, d]) hist[a][b][c][d] = '0;
            phase = '0;
        end else if (mode == iqd_pkg::MODE_BYPASS) begin
            expected_q.push_back({s.q, s.i});
        end else begin
            yi = biquad_cascade(mode - 1, 0, {{9{s.i[23]}}, s.i, 7'd0});
            yq = biquad_cascade(mode - 1, 1, {{9{s.q[23]}}, s.q, 7'd0});
            emit = (phase % (4'd1 << mode)) == 0;
            phase = phase + 4'd1;
            if (emit) expected_q.push_back({round_out(yq), round_out(yi)});
        end
    endtask

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // driver
    int src_gap;
    always @(posedge i_clk) begin
        sample_t nxt;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sample({s_axis_tuser, s_axis_tdata});
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    nxt = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.cmd;
                    s_axis_tdata  <= {nxt.q, nxt.i};
                    if (!quiet && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 17);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int sink_gap;
    always @(posedge i_clk) begin
        logic [47:0] want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected i_out", m_axis_tdata[23:0], 24'h0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata[23:0] !== want[23:0])
                        report_mismatch("i_out", m_axis_tdata[23:0], want[23:0]);
                    if (m_axis_tdata[47:24] !== want[47:24])
                        report_mismatch("q_out", m_axis_tdata[47:24], want[47:24]);
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                sink_gap <= $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 255)) - 24'd128;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic sample_t mk(logic cmd, logic [23:0] i, logic [23:0] q);
        sample_t s;
        s.cmd = cmd; s.i = i; s.q = q;
        return s;
    endfunction

    task automatic drain_and_set(logic [1:0] m);
        while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
            @(posedge i_clk);
        // filtered items without output may still be in flight, or a clearing pass
        repeat (300) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode = m;
    endtask

    initial begin
        logic [1:0] m;
        int n_items;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        errors = 0; n_results = 0; n_sent = 0; cycles = 0; quiet = 0;
        src_gap = 0; sink_gap = 0;
        foreach (hist[a, b, c, d]) hist[a][b][c][d] = '0;
        phase = '0; mode = iqd_pkg::MODE_BYPASS;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bypass extremes, then full-scale inputs through the dec2 and dec8 filters
        pending_q.push_back(mk(CMD_SAMPLE, 24'h7fffff, 24'h800000));
        pending_q.push_back(mk(CMD_SAMPLE, 24'h800000, 24'h7fffff));
        pending_q.push_back(mk(CMD_SAMPLE, 24'h000000, 24'hffffff));
        pending_q.push_back(mk(CMD_CLEAR, 24'h123456, 24'habcdef));
        drain_and_set(MODE_DEC2);
        for (int k = 0; k < 6; k++)
            pending_q.push_back(mk(CMD_SAMPLE, 24'h7fffff, 24'h800000));
        pending_q.push_back(mk(CMD_CLEAR, 24'hffffff, 24'hffffff));
        for (int k = 0; k < 3; k++)
            pending_q.push_back(mk(CMD_SAMPLE, 24'h800000, 24'h7fffff));
        drain_and_set(MODE_DEC8);
        for (int k = 0; k < 9; k++)
            pending_q.push_back(mk(CMD_SAMPLE, (k % 2) ? 24'h7fffff : 24'h800000,
                                   24'h000001));

        // random phases with mode changes; filter history of each mode persists
        n_items = 0;
        while (n_items < 1100) begin
            m = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0) m = MODE_DEC4;
            drain_and_set(m);
            if (n_items > 900) quiet = 1;
            for (int k = 0; k < $urandom_range(20, 90); k++) begin
                if ($urandom_range(0, 49) == 0)
                    pending_q.push_back(mk(CMD_CLEAR, 24'($urandom), 24'($urandom)));
                else
                    pending_q.push_back(mk(CMD_SAMPLE, rand_sample(), rand_sample()));
                n_items++;
            end
        end
        drain_and_set(iqd_pkg::MODE_BYPASS);

        $display("sent %0d items, checked %0d results over all four modes",
                 n_sent, n_results);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
sv/iqd_pkg.sv
sv/iqd_mac.sv
sv/iqd_hist_ram.sv
sv/iq_iir_decimator_top.sv
tb/tb_top.sv
